[rtl/vbms_pkg.sv]
package vbms_pkg;

  localparam int LANES               = 8;
  localparam int WORD_W              = 32;
  localparam int VEC_W               = LANES * WORD_W;
  localparam int DEFAULT_MAX_VECTORS = 64;
  localparam int CFG_W               = 3;
  localparam logic [CFG_W-1:0] CFG_RESET = 3'd6;
  localparam int NET_LAYERS          = 4;
  localparam int LAYER_W             = 2;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef word_t [LANES-1:0] vec_t;

  typedef struct packed {
    logic               load_lo;
    logic               load_hi;
    logic               step;
    logic [LAYER_W-1:0] layer;
  } net_ctrl_t;

endpackage

[rtl/vbms_store.sv]
module vbms_store #(
  parameter int AW = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  vbms_pkg::vec_t wdata_i,
  input  logic          re_a_i,
  input  logic [AW-1:0] raddr_a_i,
  output vbms_pkg::vec_t rdata_a_o,
  input  logic          re_b_i,
  input  logic [AW-1:0] raddr_b_i,
  output vbms_pkg::vec_t rdata_b_o
);
  import vbms_pkg::*;

  vec_t mem [2**AW];
  vec_t rdata_a_q;
  vec_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_a_i) begin
      rdata_a_q <= mem[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[rtl/vbms_net.sv]
module vbms_net (
  input  logic                clk_i,
  input  vbms_pkg::net_ctrl_t ctrl_i,
  input  vbms_pkg::vec_t      lo_i,
  input  vbms_pkg::vec_t      hi_i,
  output vbms_pkg::vec_t      lo_o,
  output vbms_pkg::vec_t      hi_o
);
  import vbms_pkg::*;

  word_t [2*LANES-1:0] v_q;
  word_t [2*LANES-1:0] v_d;
  word_t [2*LANES-1:0] stepped;

  // One compare layer per cycle while step is set: first the cross layer between the two
  // halves, then the half-cleaner layers at distance four, two and one.
  always_comb begin
    int d;
    stepped = v_q;
    d = LANES >> ctrl_i.layer;
    if (ctrl_i.layer == '0) begin
      for (int i = 0; i < LANES; i++) begin
        if (v_q[i] <= v_q[2*LANES-1-i]) begin
          stepped[i]       = v_q[i];
          stepped[LANES+i] = v_q[2*LANES-1-i];
        end else begin
          stepped[i]       = v_q[2*LANES-1-i];
          stepped[LANES+i] = v_q[i];
        end
      end
    end else begin
      for (int h = 0; h < 2; h++) begin
        for (int i = 0; i < LANES; i++) begin
          if (((i & d) == 0) && (v_q[h*LANES+i] > v_q[h*LANES+i+d])) begin
            stepped[h*LANES+i]   = v_q[h*LANES+i+d];
            stepped[h*LANES+i+d] = v_q[h*LANES+i];
          end
        end
      end
    end
  end

  always_comb begin
    v_d = v_q;
    if (ctrl_i.step) begin
      v_d = stepped;
    end
    if (ctrl_i.load_lo) begin
      v_d[LANES-1:0] = lo_i;
    end
    if (ctrl_i.load_hi) begin
      v_d[2*LANES-1:LANES] = hi_i;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  assign lo_o = v_q[LANES-1:0];
  assign hi_o = v_q[2*LANES-1:LANES];

endmodule

[rtl/vector_bitonic_merge_sort_top.sv]
// Sorts a job of 2^log_vector_count vectors of eight signed 32-bit lanes,
// each vector presorted ascending. Input beats are taken one per cycle while
// loading, with no result until the job's last vector has arrived. Merge
// passes then run out of two vector-wide stores in ping-pong. Each merge step
// runs four compare layers of the shared 8+8 merge network and then a
// decision state with write-back. Each run pair adds a first read, a network
// load and a tail write, and a job makes log2(N) passes for N vectors. The
// sorted vectors then leave one beat at a time, each read, registered and
// held until taken, with tlast on the final one. No new input is accepted
// until the last beat has been taken.
module vector_bitonic_merge_sort_top #(
  parameter int MAX_VECTORS = vbms_pkg::DEFAULT_MAX_VECTORS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [vbms_pkg::CFG_W-1:0] cfg_wdata_i,     // log_vector_count
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [vbms_pkg::VEC_W-1:0] s_axis_tdata_i,  // lane_0 .. lane_7
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [vbms_pkg::VEC_W-1:0] m_axis_tdata_o,  // out_0 .. out_7
  output logic                       m_axis_tlast_o   // last_vector
);
  import vbms_pkg::*;

  localparam int MAXLOG = $clog2(MAX_VECTORS + 1) - 1;
  localparam int CW     = MAXLOG + 1;
  localparam int AW     = (MAXLOG > 0) ? MAXLOG : 1;

  typedef enum logic [8:0] {
    S_LOAD      = 9'b000000001,
    S_PAIR_RD   = 9'b000000010,
    S_PAIR_LD   = 9'b000000100,
    S_NET       = 9'b000001000,
    S_DEC       = 9'b000010000,
    S_TAIL      = 9'b000100000,
    S_EMIT_RD   = 9'b001000000,
    S_EMIT_LD   = 9'b010000000,
    S_EMIT_WAIT = 9'b100000000
  } state_e;

  state_e             state_q, state_d;
  logic [CFG_W-1:0]   log_q, log_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      s_q, s_d;
  logic [CW-1:0]      r_q, r_d;
  logic [CW-1:0]      p1_q, p1_d;
  logic [CW-1:0]      p2_q, p2_d;
  logic [CW-1:0]      w_q, w_d;
  logic [LAYER_W-1:0] layer_q, layer_d;
  logic               src_sel_q, src_sel_d;
  logic               out_valid_q, out_valid_d;
  logic               out_last_q, out_last_d;
  vec_t               out_q, out_d;

  logic [CW-1:0] n_vec;
  logic [CW-1:0] mid;
  logic [CW-1:0] run_end;

  logic          re_a, re_b, we_dst, we_load;
  logic [AW-1:0] addr_a, addr_b, waddr;
  vec_t          wdata;
  vec_t          rd0_a, rd0_b, rd1_a, rd1_b, src_a, src_b;
  net_ctrl_t     net_ctrl;
  vec_t          net_lo_in, net_lo, net_hi;
  logic          have_a, have_b;

  always_comb begin
    if (int'(log_q) > MAXLOG) begin
      n_vec = CW'(1) << MAXLOG;
    end else begin
      n_vec = CW'(1) << log_q;
    end
  end

  assign mid     = s_q + r_q;
  assign run_end = s_q + (r_q << 1);
  assign src_a   = src_sel_q ? rd1_a : rd0_a;
  assign src_b   = src_sel_q ? rd1_b : rd0_b;
  assign have_a  = p1_q < mid;
  assign have_b  = p2_q < run_end;

  assign s_axis_tready_o = (state_q == S_LOAD);

  always_comb begin
    state_d     = state_q;
    log_d       = log_q;
    cnt_d       = cnt_q;
    s_d         = s_q;
    r_d         = r_q;
    p1_d        = p1_q;
    p2_d        = p2_q;
    w_d         = w_q;
    layer_d     = layer_q;
    src_sel_d   = src_sel_q;
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    out_d       = out_q;
    re_a        = 1'b0;
    re_b        = 1'b0;
    addr_a      = s_q[AW-1:0];
    addr_b      = mid[AW-1:0];
    we_load     = 1'b0;
    we_dst      = 1'b0;
    waddr       = w_q[AW-1:0];
    wdata       = net_lo;
    net_ctrl    = '0;
    net_lo_in   = src_a;

    unique case (state_q)
      S_LOAD: begin
        waddr = cnt_q[AW-1:0];
        wdata = vec_t'(s_axis_tdata_i);
        if (s_axis_tvalid_i) begin
          we_load = 1'b1;
          cnt_d   = cnt_q + 1'b1;
          if (cnt_q + 1'b1 == n_vec) begin
            cnt_d     = '0;
            s_d       = '0;
            r_d       = CW'(1);
            src_sel_d = 1'b0;
            state_d   = (n_vec == CW'(1)) ? S_EMIT_RD : S_PAIR_RD;
          end
        end
      end
      S_PAIR_RD: begin
        re_a    = 1'b1;
        re_b    = 1'b1;
        state_d = S_PAIR_LD;
      end
      S_PAIR_LD: begin
        net_ctrl.load_lo = 1'b1;
        net_ctrl.load_hi = 1'b1;
        p1_d    = s_q + 1'b1;
        p2_d    = mid + 1'b1;
        w_d     = s_q;
        layer_d = '0;
        state_d = S_NET;
      end
      S_NET: begin
        net_ctrl.step  = 1'b1;
        net_ctrl.layer = layer_q;
        // Fetch both run heads while the network works on the current pair.
        if (layer_q == '0) begin
          re_a   = have_a;
          re_b   = have_b;
          addr_a = p1_q[AW-1:0];
          addr_b = p2_q[AW-1:0];
        end
        layer_d = layer_q + 1'b1;
        if (layer_q == LAYER_W'(NET_LAYERS - 1)) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        we_dst  = 1'b1;
        w_d     = w_q + 1'b1;
        layer_d = '0;
        if (have_a && (!have_b || !(src_a[0] > src_b[0]))) begin
          net_ctrl.load_lo = 1'b1;
          net_lo_in        = src_a;
          p1_d             = p1_q + 1'b1;
          state_d          = S_NET;
        end else if (have_b) begin
          net_ctrl.load_lo = 1'b1;
          net_lo_in        = src_b;
          p2_d             = p2_q + 1'b1;
          state_d          = S_NET;
        end else begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        we_dst = 1'b1;
        wdata  = net_hi;
        if (run_end == n_vec) begin
          src_sel_d = ~src_sel_q;
          s_d       = '0;
          if ((r_q << 1) == n_vec) begin
            cnt_d   = '0;
            state_d = S_EMIT_RD;
          end else begin
            r_d     = r_q << 1;
            state_d = S_PAIR_RD;
          end
        end else begin
          s_d     = run_end;
          state_d = S_PAIR_RD;
        end
      end
      S_EMIT_RD: begin
        re_a    = 1'b1;
        addr_a  = cnt_q[AW-1:0];
        state_d = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        out_d       = src_a;
        out_valid_d = 1'b1;
        out_last_d  = (cnt_q == n_vec - 1'b1);
        state_d     = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (m_axis_tready_i) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            cnt_d   = '0;
            state_d = S_LOAD;
          end else begin
            cnt_d   = cnt_q + 1'b1;
            state_d = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase

    // A new job size drops any partly loaded job.
    if (cfg_we_i) begin
      log_d = cfg_wdata_i;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      log_q       <= CFG_RESET;
      cnt_q       <= '0;
      s_q         <= '0;
      r_q         <= '0;
      p1_q        <= '0;
      p2_q        <= '0;
      w_q         <= '0;
      layer_q     <= '0;
      src_sel_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      log_q       <= log_d;
      cnt_q       <= cnt_d;
      s_q         <= s_d;
      r_q         <= r_d;
      p1_q        <= p1_d;
      p2_q        <= p2_d;
      w_q         <= w_d;
      layer_q     <= layer_d;
      src_sel_q   <= src_sel_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // While merging, reads hit the source store and writes the other one, so a read
  // and a write never meet on the same entry.
  vbms_store #(.AW(AW)) u_store0 (
    .clk_i     (clk_i),
    .we_i      (we_load | (we_dst & src_sel_q)),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_a_i    (re_a & ~src_sel_q),
    .raddr_a_i (addr_a),
    .rdata_a_o (rd0_a),
    .re_b_i    (re_b & ~src_sel_q),
    .raddr_b_i (addr_b),
    .rdata_b_o (rd0_b)
  );

  vbms_store #(.AW(AW)) u_store1 (
    .clk_i     (clk_i),
    .we_i      (we_dst & ~src_sel_q),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_a_i    (re_a & src_sel_q),
    .raddr_a_i (addr_a),
    .rdata_a_o (rd1_a),
    .re_b_i    (re_b & src_sel_q),
    .raddr_b_i (addr_b),
    .rdata_b_o (rd1_b)
  );

  vbms_net u_net (
    .clk_i  (clk_i),
    .ctrl_i (net_ctrl),
    .lo_i   (net_lo_in),
    .hi_i   (src_b),
    .lo_o   (net_lo),
    .hi_o   (net_hi)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

[rtl/vbms_checker.sv]
module vbms_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tready_o,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [vbms_pkg::VEC_W-1:0] m_axis_tdata_o,
  input logic                       m_axis_tlast_o
);
  import vbms_pkg::*;

  // Loading and emitting never overlap.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while a result is pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled output beat changed");

  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i |=> !m_axis_tvalid_o)
    else $error("output valid right after a taken beat");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o |=> s_axis_tready_o)
    else $error("not ready for a new job after the last beat");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=> !s_axis_tready_o)
    else $error("ready for input in the middle of the output");

endmodule

bind vector_bitonic_merge_sort_top vbms_checker u_vbms_checker (.*);

[test/tb_vector_bitonic_merge_sort_top.sv]
module tb_vector_bitonic_merge_sort_top;
  import vbms_pkg::*;

  localparam int StoreDepth = DEFAULT_MAX_VECTORS * LANES;
  localparam int IdleLimit  = 20000;

  typedef struct {
    vec_t data;
    logic last;
  } sorted_beat_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [VEC_W-1:0] s_axis_tdata_i = '0;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [VEC_W-1:0] m_axis_tdata_o;
  logic             m_axis_tlast_o;

  vector_bitonic_merge_sort_top i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tlast_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  vec_t         pending_vecs[$];
  sorted_beat_t sorted_q[$];
  word_t        bank[2][StoreDepth];
  int           loaded_cnt = 0;
  logic [CFG_W-1:0] log_cnt = CFG_RESET;
  int           fail_cnt = 0;
  bit           beat_taken = 1'b0;
  bit           long_hold_req = 1'b0;

  function automatic int vectors_per_job();
    int n;
    n = 1 << log_cnt;
    if (n > DEFAULT_MAX_VECTORS) n = DEFAULT_MAX_VECTORS;
    return n;
  endfunction

  function automatic bit greater(word_t a, word_t b);
    return $signed(a) > $signed(b);
  endfunction

  function automatic void clean_bitonic(inout vec_t v);
    word_t x;
    for (int d = LANES / 2; d > 0; d = d / 2) begin
      for (int i = 0; i < LANES; i++) begin
        if ((i & d) == 0 && greater(v[i], v[i+d])) begin
          x = v[i];
          v[i] = v[i+d];
          v[i+d] = x;
        end
      end
    end
  endfunction

  // Lower eight end up in lo, upper eight in hi.
  function automatic void merge_pair(inout vec_t lo, inout vec_t hi);
    vec_t a, b;
    for (int i = 0; i < LANES; i++) begin
      if (!greater(lo[i], hi[LANES-1-i])) begin
        a[i] = lo[i];
        b[i] = hi[LANES-1-i];
      end else begin
        a[i] = hi[LANES-1-i];
        b[i] = lo[i];
      end
    end
    clean_bitonic(a);
    clean_bitonic(b);
    lo = a;
    hi = b;
  endfunction

  function automatic vec_t read_vec(int s, int base);
    vec_t v;
    for (int l = 0; l < LANES; l++) v[l] = bank[s][base+l];
    return v;
  endfunction

  function automatic void write_vec(int d, int base, vec_t v);
    for (int l = 0; l < LANES; l++) bank[d][base+l] = v[l];
  endfunction

  function automatic void merge_runs(int s, int start, int mid, int stop);
    vec_t ra, rb;
    int   p1, p2, w, d;
    d  = 1 - s;
    p1 = start + LANES;
    p2 = mid + LANES;
    w  = start;
    ra = read_vec(s, start);
    rb = read_vec(s, mid);
    while (p1 < mid && p2 < stop) begin
      merge_pair(ra, rb);
      write_vec(d, w, ra);
      w += LANES;
      if (greater(bank[s][p1], bank[s][p2])) begin
        ra = read_vec(s, p2);
        p2 += LANES;
      end else begin
        ra = read_vec(s, p1);
        p1 += LANES;
      end
    end
    merge_pair(ra, rb);
    write_vec(d, w, ra);
    w += LANES;
    while (p1 < mid) begin
      ra = read_vec(s, p1);
      p1 += LANES;
      merge_pair(ra, rb);
      write_vec(d, w, ra);
      w += LANES;
    end
    while (p2 < stop) begin
      ra = read_vec(s, p2);
      p2 += LANES;
      merge_pair(ra, rb);
      write_vec(d, w, ra);
      w += LANES;
    end
    write_vec(d, w, rb);
  endfunction

  function automatic void absorb_vector(vec_t v);
    int nvec, total, s;
    sorted_beat_t b;
    nvec = vectors_per_job();
    if (loaded_cnt >= nvec) loaded_cnt = 0;
    write_vec(0, loaded_cnt * LANES, v);
    loaded_cnt++;
    if (loaded_cnt < nvec) return;
    total = nvec * LANES;
    s = 0;
    for (int run = LANES; run < total; run *= 2) begin
      for (int i = 0; i < total; i += 2 * run) merge_runs(s, i, i + run, i + 2 * run);
      s = 1 - s;
    end
    for (int k = 0; k < nvec; k++) begin
      b.data = read_vec(s, k * LANES);
      b.last = (k + 1 == nvec);
      sorted_q.push_back(b);
    end
    loaded_cnt = 0;
  endfunction

  function automatic word_t random_word(int spread);
    case (spread)
      0: return word_t'($urandom_range(0, 7)) - 4;
      1: return ($urandom_range(0, 1)) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic vec_t make_vector();
    vec_t  v;
    word_t x;
    int    spread;
    spread = $urandom_range(0, 5);
    for (int l = 0; l < LANES; l++) v[l] = random_word(spread > 2 ? 2 : spread);
    // A few vectors are left unsorted on purpose.
    if ($urandom_range(0, 24) != 0) begin
      for (int i = 1; i < LANES; i++) begin
        for (int j = i; j > 0 && greater(v[j-1], v[j]); j--) begin
          x = v[j];
          v[j] = v[j-1];
          v[j-1] = x;
        end
      end
    end
    return v;
  endfunction

  function automatic vec_t fill_vector(word_t lo, word_t hi, int split);
    vec_t v;
    for (int l = 0; l < LANES; l++) v[l] = (l < split) ? lo : hi;
    return v;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 4;
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || beat_taken)) begin
      beat_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_vecs.size() > 0) begin
        s_axis_tdata_i  <= pending_vecs.pop_front();
        s_axis_tvalid_i <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver: changes its stall mode every so often, plus one long hold-off.
  int mode_left = 0;
  int ready_mode = 0;
  int hold_left = 0;
  always @(negedge clk_i) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = 400;
    end
    if (mode_left == 0) begin
      mode_left = $urandom_range(20, 200);
      ready_mode = $urandom_range(0, 2);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      case (ready_mode)
        0: m_axis_tready_i <= 1'b1;
        1: m_axis_tready_i <= 1'($urandom_range(0, 1));
        default: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  int idle_cycles = 0;
  always @(posedge clk_i) begin
    sorted_beat_t exp_beat;
    vec_t got;
    if (rst_ni) begin
      if (cfg_we_i) begin
        log_cnt = cfg_wdata_i;
        loaded_cnt = 0;
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        absorb_vector(s_axis_tdata_i);
        beat_taken = 1'b1;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = m_axis_tdata_o;
        if (sorted_q.size() == 0) begin
          $error("unexpected output beat %h", m_axis_tdata_o);
          fail_cnt++;
        end else begin
          exp_beat = sorted_q.pop_front();
          for (int l = 0; l < LANES; l++) begin
            if (got[l] !== exp_beat.data[l]) begin
              $error("out_%0d: expected %0d, got %0d", l, exp_beat.data[l], got[l]);
              fail_cnt++;
            end
          end
          if (m_axis_tlast_o !== exp_beat.last) begin
            $error("last_vector: expected %0b, got %0b", exp_beat.last, m_axis_tlast_o);
            fail_cnt++;
          end
        end
      end
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_vecs.size() > 0 || s_axis_tvalid_i || sorted_q.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_log_count(logic [CFG_W-1:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) pending_vecs.push_back(make_vector());
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // First job runs with the reset size of 64 vectors, opening with edge values.
    pending_vecs.push_back(fill_vector(32'h8000_0000, 32'h8000_0000, 0));
    pending_vecs.push_back(fill_vector(32'h7fff_ffff, 32'h7fff_ffff, 0));
    pending_vecs.push_back(fill_vector(32'h8000_0000, 32'h7fff_ffff, 4));
    pending_vecs.push_back(fill_vector(32'h0000_0000, 32'h0000_0000, 0));
    pending_vecs.push_back(fill_vector(32'hffff_ffff, 32'h0000_0001, 3));
    pending_vecs.push_back(fill_vector(32'haaaa_aaaa, 32'h5555_5555, 5));
    pending_vecs.push_back(fill_vector(32'h8000_0000, 32'h0000_0000, 1));
    pending_vecs.push_back(fill_vector(32'h0000_0000, 32'h7fff_ffff, 7));
    pending_vecs.push_back(fill_vector(32'hffff_ffff, 32'hffff_ffff, 0));
    pending_vecs.push_back(fill_vector(32'h8000_0000, 32'h7fff_ffff, 4));
    queue_random(54);

    // Single-vector jobs, with a long receiver hold-off at the start.
    write_log_count(3'd0);
    long_hold_req = 1'b1;
    queue_random(10);

    write_log_count(3'd1);
    queue_random(20);

    // A partly loaded job is dropped by the next register write.
    write_log_count(3'd2);
    queue_random(35);

    write_log_count(3'd3);
    queue_random(48);

    // Oversized setting saturates to 64 vectors.
    write_log_count(3'd7);
    queue_random(64);

    write_log_count(3'd4);
    queue_random(48);

    write_log_count(3'd5);
    queue_random(32);

    wait_drained();
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/vbms_pkg.sv
rtl/vbms_store.sv
rtl/vbms_net.sv
rtl/vector_bitonic_merge_sort_top.sv
rtl/vbms_checker.sv
test/tb_vector_bitonic_merge_sort_top.sv
